// File: sv/hct_pkg.sv
// hop channel table package: transaction types, command and register codes,
// reset values and default sizes used by hct_divmod and the hop channel table top level

package hct_pkg;

  localparam int unsigned CHANNEL_COUNT_DEF = 128;
  localparam int unsigned TABLE_DEPTH_DEF   = 128;

  localparam int unsigned CH_W   = 7;
  localparam int unsigned CAND_W = 8;
  localparam int unsigned DG_W   = 16;
  localparam int unsigned SIZE_W = 8;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned REG_W  = 2;

  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_OFFER   = 2'd1;
  localparam logic [1:0] CMD_HOP     = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [REG_W-1:0] REG_MAX_CHANNEL = 2'd0;
  localparam logic [REG_W-1:0] REG_RESERVED_A  = 2'd1;
  localparam logic [REG_W-1:0] REG_RESERVED_B  = 2'd2;
  localparam logic [REG_W-1:0] REG_TABLE_SIZE  = 2'd3;

  localparam logic [CH_W-1:0]   MAX_CHANNEL_RST = 7'd82;
  localparam logic [CH_W-1:0]   RESERVED_A_RST  = 7'd0;
  localparam logic [CH_W-1:0]   RESERVED_B_RST  = 7'd1;
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST  = 8'd81;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CAND_W-1:0] candidate;
    logic [DG_W-1:0]   datagram_number;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            accepted;
    logic            fill_done;
  } out_t;

endpackage

// File: sv/hct_ram.sv
// hop channel table generic memory: one write port, one registered read port
// no dependencies

module hct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/hct_divmod.sv
// hop channel table serial remainder unit: datagram number modulo table size,
// one restoring subtract per cycle; uses hct_pkg

module hct_divmod
  import hct_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [DG_W-1:0]                  dividend_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] divisor_i,
  output logic                             done_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] rem_o
);

  localparam int unsigned SzW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CntW = $clog2(DG_W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DG_W-1:0] num_q, num_d;
  logic [SzW-1:0]  rem_q, rem_d;
  logic [SzW-1:0]  div_q, div_d;
  logic [SzW:0]    trial;
  logic [SzW:0]    diff;

  assign trial = {rem_q, num_q[DG_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[DG_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[SzW-1:0];
      end else begin
        rem_d = trial[SzW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/hop_channel_table.sv
// hop channel table top level: config registers, sequencer, used map and slot memories
// depends on hct_pkg, hct_ram, hct_divmod
// offer: used map lookup, then check and slot write; hop: serial remainder, then slot read;
// restart: used map sweep, then reserved channels marked; unused command: result emitted directly
// one transaction at a time, next one taken the cycle after the result is registered
// reset: used map clearing pass over all CHANNEL_COUNT entries, no input accepted meanwhile

module hop_channel_table
  import hct_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF,
  parameter int unsigned TABLE_DEPTH   = TABLE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [REG_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o
);

  localparam int unsigned ChW   = $clog2(CHANNEL_COUNT);
  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned SzW   = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_RES_A = 4'd1;
  localparam logic [3:0] ST_RES_B = 4'd2;
  localparam logic [3:0] ST_IDLE  = 4'd3;
  localparam logic [3:0] ST_LOOK  = 4'd4;
  localparam logic [3:0] ST_CHECK = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_SLOT  = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  logic [CH_W-1:0]   max_channel_q;
  logic [CH_W-1:0]   res_a_q;
  logic [CH_W-1:0]   res_b_q;
  logic [SIZE_W-1:0] table_size_q;

  logic [3:0]        state_q, state_d;
  logic              mark_q, mark_d;
  logic [ChW-1:0]    clr_q, clr_d;
  logic [SzW-1:0]    fill_q, fill_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  logic [CAND_W-1:0] cand_q, cand_d;
  logic [CH_W-1:0]   res_ch_q, res_ch_d;
  logic              res_acc_q, res_acc_d;

  logic [8:0]        ts_ext;
  logic [8:0]        size_clamp;
  logic [SzW-1:0]    eff_size;
  logic [8:0]        cand_ext;
  logic [8:0]        res_a_ext;
  logic [8:0]        res_b_ext;
  logic              cand_ok;
  logic              emit_free;

  logic              used_we;
  logic [ChW-1:0]    used_waddr;
  logic              used_wdata;
  logic              used_re;
  logic              used_rdata;
  logic              slot_we;
  logic              slot_re;
  logic [AddrW-1:0]  slot_raddr;
  logic [CH_W-1:0]   slot_rdata;
  logic              div_start;
  logic              div_done;
  logic [SzW-1:0]    div_rem;

  // effective table size clamped to 1..TABLE_DEPTH
  always_comb begin
    ts_ext = {1'b0, table_size_q};
    if (ts_ext == 9'd0) begin
      size_clamp = 9'd1;
    end else if (ts_ext > 9'(TABLE_DEPTH)) begin
      size_clamp = 9'(TABLE_DEPTH);
    end else begin
      size_clamp = ts_ext;
    end
  end
  assign eff_size = size_clamp[SzW-1:0];

  assign cand_ext  = {1'b0, cand_q};
  assign res_a_ext = {2'b00, res_a_q};
  assign res_b_ext = {2'b00, res_b_q};
  assign cand_ok   = (cand_ext <= {2'b00, max_channel_q}) && (cand_ext < 9'(CHANNEL_COUNT));
  assign emit_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_channel_q <= MAX_CHANNEL_RST;
      res_a_q       <= RESERVED_A_RST;
      res_b_q       <= RESERVED_B_RST;
      table_size_q  <= TABLE_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MAX_CHANNEL: max_channel_q <= cfg_wdata_i[CH_W-1:0];
        REG_RESERVED_A:  res_a_q       <= cfg_wdata_i[CH_W-1:0];
        REG_RESERVED_B:  res_b_q       <= cfg_wdata_i[CH_W-1:0];
        REG_TABLE_SIZE:  table_size_q  <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    mark_d      = mark_q;
    clr_d       = clr_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cand_d      = cand_q;
    res_ch_d    = res_ch_q;
    res_acc_d   = res_acc_q;
    used_we     = 1'b0;
    used_waddr  = cand_q[ChW-1:0];
    used_wdata  = 1'b1;
    used_re     = 1'b0;
    slot_we     = 1'b0;
    slot_re     = 1'b0;
    slot_raddr  = div_rem[AddrW-1:0];
    div_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_q;
        used_wdata = 1'b0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == ChW'(CHANNEL_COUNT - 1)) begin
          state_d = mark_q ? ST_RES_A : ST_IDLE;
        end
      end
      ST_RES_A: begin
        used_we    = res_a_ext < 9'(CHANNEL_COUNT);
        used_waddr = res_a_ext[ChW-1:0];
        state_d    = ST_RES_B;
      end
      ST_RES_B: begin
        used_we    = res_b_ext < 9'(CHANNEL_COUNT);
        used_waddr = res_b_ext[ChW-1:0];
        res_ch_d   = '0;
        res_acc_d  = 1'b0;
        state_d    = ST_EMIT;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cand_d    = in_data_i.candidate;
          res_ch_d  = '0;
          res_acc_d = 1'b0;
          unique case (in_data_i.cmd)
            CMD_RESTART: begin
              mark_d  = 1'b1;
              clr_d   = '0;
              fill_d  = '0;
              state_d = ST_CLEAR;
            end
            CMD_OFFER: state_d = ST_LOOK;
            CMD_HOP: begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
            CMD_NONE: state_d = ST_EMIT;
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_LOOK: begin
        used_re = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if ((fill_q < eff_size) && cand_ok && !used_rdata) begin
          used_we   = 1'b1;
          slot_we   = 1'b1;
          fill_d    = fill_q + 1'b1;
          res_ch_d  = cand_q[CH_W-1:0];
          res_acc_d = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_DIV: begin
        if (div_done) begin
          slot_re = 1'b1;
          state_d = ST_SLOT;
        end
      end
      ST_SLOT: begin
        res_ch_d = slot_rdata;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_free) begin
          out_valid_d       = 1'b1;
          out_d.channel     = res_ch_q;
          out_d.accepted    = res_acc_q;
          out_d.fill_done   = fill_q >= eff_size;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mark_q      <= 1'b0;
      clr_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mark_q      <= mark_d;
      clr_q       <= clr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    cand_q    <= cand_d;
    res_ch_q  <= res_ch_d;
    res_acc_q <= res_acc_d;
  end

  hct_ram #(
    .WIDTH (1),
    .DEPTH (CHANNEL_COUNT)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .re_i    (used_re),
    .raddr_i (cand_q[ChW-1:0]),
    .rdata_o (used_rdata)
  );

  hct_ram #(
    .WIDTH (CH_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i (cand_q[CH_W-1:0]),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  hct_divmod #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_divmod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_data_i.datagram_number),
    .divisor_i  (eff_size),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
